>>> rtl/mrt_pkg.sv
package mrt_pkg;

    typedef struct packed {
        logic green_pressed;
        logic red_pressed;
    } in_t;

    typedef struct packed {
        logic relay_on;
        logic direction_pin;
        logic overload_lamp;
    } out_t;

    typedef enum logic [2:0] {
        MODE_WAIT  = 3'd0,
        MODE_ARMED = 3'd1,
        MODE_HOLD  = 3'd2,
        MODE_COUNT = 3'd3,
        MODE_CLEAR = 3'd4,
        MODE_OVER  = 3'd5
    } mode_t;

    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RUN_TICKS       = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OVERLOAD_LIMIT  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OVERLOAD_RESUME = 2'd2;

    localparam int RUN_TICKS_RESET       = 602400;
    localparam int OVERLOAD_LIMIT_RESET  = 18072000;
    localparam int OVERLOAD_RESUME_RESET = 16264800;

endpackage

>>> rtl/mrt_core.sv
module mrt_core
    import mrt_pkg::*;
#(
    parameter int COUNT_WIDTH = 25
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  in_t                    item,
    input  logic [COUNT_WIDTH-1:0] run_ticks,
    input  logic [COUNT_WIDTH-1:0] overload_limit,
    input  logic [COUNT_WIDTH-1:0] overload_resume,
    output out_t                   result
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    mode_t                  mode_reg, mode_next;
    logic [COUNT_WIDTH-1:0] countdown_reg, countdown_next;
    logic [COUNT_WIDTH-1:0] heat_reg, heat_next;
    logic                   relay_req_reg, relay_req_next;
    logic                   chosen_dir_reg, chosen_dir_next;
    logic                   dir_latch_reg, dir_latch_next;
    logic                   over_flag_reg, over_flag_next;

    logic                   any_pressed;
    logic [COUNT_WIDTH-1:0] heat_up;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_WAIT;
            countdown_reg  <= '0;
            heat_reg       <= '0;
            relay_req_reg  <= 1'b0;
            chosen_dir_reg <= 1'b0;
            dir_latch_reg  <= 1'b0;
            over_flag_reg  <= 1'b0;
        end else if (advance) begin
            mode_reg       <= mode_next;
            countdown_reg  <= countdown_next;
            heat_reg       <= heat_next;
            relay_req_reg  <= relay_req_next;
            chosen_dir_reg <= chosen_dir_next;
            dir_latch_reg  <= dir_latch_next;
            over_flag_reg  <= over_flag_next;
        end
    end

    // Modes fall through in one combinational pass: wait, armed, hold, countdown, clear, overload.
    always_comb begin
        any_pressed     = item.green_pressed | item.red_pressed;
        mode_next       = mode_reg;
        countdown_next  = countdown_reg;
        relay_req_next  = relay_req_reg;
        chosen_dir_next = chosen_dir_reg;
        dir_latch_next  = dir_latch_reg;
        over_flag_next  = over_flag_reg;
        heat_next       = heat_reg;
        heat_up         = heat_reg;

        if (mode_next == MODE_WAIT && !any_pressed) begin
            mode_next = MODE_ARMED;
        end

        if (mode_next == MODE_ARMED && any_pressed) begin
            chosen_dir_next = ~item.green_pressed;
            mode_next       = MODE_HOLD;
        end

        if (mode_next == MODE_HOLD) begin
            countdown_next = run_ticks;
            relay_req_next = 1'b1;
            if (!any_pressed) begin
                mode_next = MODE_COUNT;
            end
        end

        if (mode_next == MODE_COUNT) begin
            if (countdown_next <= CNT_ONE) begin
                countdown_next = '0;
                mode_next      = MODE_CLEAR;
            end else begin
                countdown_next = countdown_next - CNT_ONE;
            end
            if (any_pressed) begin
                mode_next = MODE_ARMED;
            end
        end

        if (mode_next == MODE_CLEAR) begin
            relay_req_next = 1'b0;
            mode_next      = MODE_ARMED;
        end

        if (mode_next == MODE_OVER) begin
            over_flag_next = 1'b1;
            relay_req_next = 1'b0;
            if (heat_reg <= overload_resume) begin
                over_flag_next = 1'b0;
                mode_next      = MODE_WAIT;
            end
        end

        if (heat_reg >= overload_limit) begin
            mode_next = MODE_OVER;
        end

        if (relay_req_next) begin
            dir_latch_next = chosen_dir_next;
            if (heat_reg != CNT_MAX) begin
                heat_up = heat_reg + CNT_ONE;
            end
            heat_next = (heat_up > overload_limit) ? overload_limit : heat_up;
        end else if (heat_reg != '0) begin
            heat_next = heat_reg - CNT_ONE;
        end

        result.relay_on      = relay_req_next;
        result.direction_pin = dir_latch_next;
        result.overload_lamp = over_flag_next;
    end

endmodule

>>> rtl/motor_run_timer_with_overload.sv
// Channel | Ports                              | Payload
// input   | s_valid, s_ready, s_data (in_t)    | green_pressed, red_pressed
// result  | m_valid, m_ready, m_data (out_t)   | relay_on, direction_pin, overload_lamp
// config  | cfg_we, cfg_index, cfg_wdata       | run_ticks, overload_limit, overload_resume
//
// One transaction per clock while s_ready is high; the result is out the next cycle.
// The mode and counter update is a single pass between the state and output registers.
// s_ready stays high while the output register is empty or being drained.
// aresetn is synchronous, active low; all registers except m_data_reg are reset.
module motor_run_timer_with_overload
    import mrt_pkg::*;
#(
    parameter int COUNT_WIDTH = 25
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  in_t                        s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output out_t                       m_data,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [COUNT_WIDTH-1:0]     cfg_wdata
);

    logic [COUNT_WIDTH-1:0] run_ticks_reg;
    logic [COUNT_WIDTH-1:0] limit_reg;
    logic [COUNT_WIDTH-1:0] resume_reg;
    logic                   m_valid_reg;
    out_t                   m_data_reg;
    out_t                   result;
    logic                   advance;

    assign s_ready = ~m_valid_reg | m_ready;
    assign advance = s_valid & s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_ticks_reg <= COUNT_WIDTH'(RUN_TICKS_RESET);
            limit_reg     <= COUNT_WIDTH'(OVERLOAD_LIMIT_RESET);
            resume_reg    <= COUNT_WIDTH'(OVERLOAD_RESUME_RESET);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_RUN_TICKS:       run_ticks_reg <= cfg_wdata;
                CFG_OVERLOAD_LIMIT:  limit_reg     <= cfg_wdata;
                CFG_OVERLOAD_RESUME: resume_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= result;
        end
    end

    mrt_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .item            (s_data),
        .run_ticks       (run_ticks_reg),
        .overload_limit  (limit_reg),
        .overload_resume (resume_reg),
        .result          (result)
    );

endmodule

>>> rtl/mrt_checker.sv
module mrt_checker
    import mrt_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped while stalled");

    a_lamp_relay: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.relay_on && m_data.overload_lamp))
        else $error("relay on during overload");

    a_dir_only_relay: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && $past(m_valid) && $past(aresetn) && !$stable(m_data.direction_pin))
            |-> m_data.relay_on)
        else $error("direction changed with relay off");

    a_ready_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input blocked while output drains");

    a_no_result_early: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(!aresetn) && !(s_valid && s_ready)) |=> !m_valid)
        else $error("result without transaction after reset");

endmodule

bind motor_run_timer_with_overload mrt_checker u_mrt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
